// ===== rtl/mftd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mftd_pkg
// Shared types and constants of the multi-finger tap detector.
// ----------------------------------------------------------------------------
package mftd_pkg;

  // Field widths of the channels
  localparam int unsigned MASK_W    = 5;
  localparam int unsigned TIME_W    = 32;
  localparam int unsigned COUNT_W   = 3;
  localparam int unsigned CFG_W     = 16;
  localparam int unsigned CFG_IDX_W = 2;

  // Register reset values (ms)
  localparam logic [CFG_W-1:0] SETTLE_RST     = 16'd50;
  localparam logic [CFG_W-1:0] RECENT_RST     = 16'd200;
  localparam logic [CFG_W-1:0] LONG_PRESS_RST = 16'd500;

  // Register indexes on the configuration channel
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SETTLE     = 2'd0,
    REG_RECENT     = 2'd1,
    REG_LONG_PRESS = 2'd2
  } cfg_reg_e;

  // Current register settings
  typedef struct packed {
    logic [CFG_W-1:0] settle_ms;
    logic [CFG_W-1:0] recent_ms;
    logic [CFG_W-1:0] long_press_ms;
  } cfg_t;

  // Per-slot result of one item
  typedef struct packed {
    logic settled;   // release at least settle_ms old
    logic tap;       // recent release with a short enough hold
  } lane_flags_t;

endpackage

// ===== rtl/mftd_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mftd interfaces
// Valid/ready channels: touch samples in, tap results out, register writes.
// ----------------------------------------------------------------------------
interface mftd_in_if;
  logic                               valid;
  logic                               ready;
  logic [mftd_pkg::MASK_W-1:0]        pressed_mask;
  logic [mftd_pkg::TIME_W-1:0]        now_ms;

  modport source (output valid, pressed_mask, now_ms, input ready);
  modport sink   (input valid, pressed_mask, now_ms, output ready);
endinterface

interface mftd_out_if;
  logic                               valid;
  logic                               ready;
  logic [mftd_pkg::COUNT_W-1:0]       tap_fingers;

  modport source (output valid, tap_fingers, input ready);
  modport sink   (input valid, tap_fingers, output ready);
endinterface

interface mftd_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [mftd_pkg::CFG_IDX_W-1:0]     index;
  logic [mftd_pkg::CFG_W-1:0]         data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/mftd_cfg_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mftd_cfg_regs
// Timing registers written over the configuration channel.
// ----------------------------------------------------------------------------
module mftd_cfg_regs (
  input  logic             clk,
  input  logic             rst,
  mftd_cfg_if.sink         cfg,
  output mftd_pkg::cfg_t   regs
);

  // Writes are always taken
  assign cfg.ready = 1'b1;

  // Register file; indexes past the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.settle_ms     <= mftd_pkg::SETTLE_RST;
      regs.recent_ms     <= mftd_pkg::RECENT_RST;
      regs.long_press_ms <= mftd_pkg::LONG_PRESS_RST;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        mftd_pkg::REG_SETTLE:     regs.settle_ms     <= cfg.data;
        mftd_pkg::REG_RECENT:     regs.recent_ms     <= cfg.data;
        mftd_pkg::REG_LONG_PRESS: regs.long_press_ms <= cfg.data;
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/mftd_slot_lane.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mftd_slot_lane
// One touch slot: down flag, press and release times, and the age and hold
// tests for the item being processed.
// ----------------------------------------------------------------------------
module mftd_slot_lane (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          step,      // item leaves the input register
  input  logic                          pressed,
  input  logic [mftd_pkg::TIME_W-1:0]   now_ms,
  input  mftd_pkg::cfg_t                regs,
  output mftd_pkg::lane_flags_t         flags
);

  logic                         down;
  logic [mftd_pkg::TIME_W-1:0]  press_time;
  logic [mftd_pkg::TIME_W-1:0]  release_time;

  logic                         down_next;
  logic [mftd_pkg::TIME_W-1:0]  press_time_next;
  logic [mftd_pkg::TIME_W-1:0]  release_time_next;
  logic [mftd_pkg::TIME_W-1:0]  age;
  logic [mftd_pkg::TIME_W-1:0]  hold;

  // Edge detection and time capture
  always_comb begin
    down_next         = pressed;
    press_time_next   = press_time;
    release_time_next = release_time;
    if (!down && pressed) begin
      press_time_next = now_ms;
    end else if (down && !pressed) begin
      release_time_next = now_ms;
    end
  end

  // Differences wrap modulo 2^32
  assign age  = now_ms - release_time_next;
  assign hold = release_time_next - press_time_next;

  assign flags.settled = age >= {{(mftd_pkg::TIME_W-mftd_pkg::CFG_W){1'b0}}, regs.settle_ms};
  assign flags.tap     = (age  <= {{(mftd_pkg::TIME_W-mftd_pkg::CFG_W){1'b0}}, regs.recent_ms})
                      && (hold <= {{(mftd_pkg::TIME_W-mftd_pkg::CFG_W){1'b0}},
                                   regs.long_press_ms});

  // Slot state
  always_ff @(posedge clk) begin
    if (rst) begin
      down         <= 1'b0;
      press_time   <= '0;
      release_time <= '0;
    end else if (step) begin
      down         <= down_next;
      press_time   <= press_time_next;
      release_time <= release_time_next;
    end
  end

endmodule

// ===== rtl/multi_finger_tap_detector_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_finger_tap_detector_top
// Path: an accepted sample goes through the input register, then the result register.
// Throughput: one sample per cycle unless the output stalls; the slot lanes work
// in parallel on the input register's sample; the result register decouples stalls.
// Reset: synchronous; clears slot state and times to zero and loads the
// registers with settle 50 ms, recent 200 ms, long press 500 ms.
// ----------------------------------------------------------------------------
module multi_finger_tap_detector_top #(
  parameter int unsigned MAX_SLOTS = 5
) (
  input  logic        clk,
  input  logic        rst,
  mftd_in_if.sink     sample,
  mftd_out_if.source  result,
  mftd_cfg_if.sink    cfg
);

  mftd_pkg::cfg_t                     regs;

  logic                               in_vld;
  logic [mftd_pkg::MASK_W-1:0]        in_mask;
  logic [mftd_pkg::TIME_W-1:0]        in_now;
  logic                               out_vld;
  logic [mftd_pkg::COUNT_W-1:0]       out_count;

  logic                               advance;
  logic                               any_down;
  logic                               any_settled;
  logic [MAX_SLOTS-1:0]               settled_vec;
  logic [MAX_SLOTS-1:0]               tap_vec;
  logic [mftd_pkg::COUNT_W-1:0]       count;
  mftd_pkg::lane_flags_t              flags [MAX_SLOTS];

  mftd_cfg_regs u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  // Handshake: the input register empties whenever the result register can load
  assign advance      = in_vld && (!out_vld || result.ready);
  assign sample.ready = !in_vld || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (sample.ready) begin
      in_vld <= sample.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sample.valid && sample.ready) begin
      in_mask <= sample.pressed_mask;
      in_now  <= sample.now_ms;
    end
  end

  // Slot lanes; mask bits above the slots are ignored
  for (genvar i = 0; i < MAX_SLOTS; i++) begin : g_slot
    mftd_slot_lane u_lane (
      .clk     (clk),
      .rst     (rst),
      .step    (advance),
      .pressed (in_mask[i]),
      .now_ms  (in_now),
      .regs    (regs),
      .flags   (flags[i])
    );
    assign settled_vec[i] = flags[i].settled;
    assign tap_vec[i]     = flags[i].tap;
  end

  // Tap count: only with every slot up and some release settled
  assign any_down    = |in_mask[MAX_SLOTS-1:0];
  assign any_settled = |settled_vec;
  assign count       = (!any_down && any_settled) ? mftd_pkg::COUNT_W'($countones(tap_vec))
                                                  : '0;

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (advance) begin
      out_vld <= 1'b1;
    end else if (result.ready) begin
      out_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_count <= count;
    end
  end

  assign result.valid       = out_vld;
  assign result.tap_fingers = out_count;

endmodule

// ===== tb/sv/multi_finger_tap_detector_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_finger_tap_detector_top_tb
// Drives touch samples and register writes into the tap detector and checks
// every tap count against an in-bench predictor. A directed opening covers the
// untouched slots, full-hand presses and the timestamp wrap. Random tap
// gestures, broken sequences and noise then run under several register
// settings, with random idling on both channels and a long output hold-off.
// ----------------------------------------------------------------------------
module multi_finger_tap_detector_top_tb;

  localparam int unsigned SLOTS         = 5;
  localparam int unsigned QUIET_CYCLES  = 4;     // past the input and result registers
  localparam int unsigned LONG_HOLD     = 400;   // output hold-off, in cycles
  localparam int unsigned STALL_LIMIT   = 5000;  // cycles with no handshake
  localparam int unsigned PHASE_ITEMS   = 155;

  typedef logic [mftd_pkg::MASK_W-1:0]  mask_t;
  typedef logic [mftd_pkg::TIME_W-1:0]  stamp_t;
  typedef logic [mftd_pkg::COUNT_W-1:0] tap_t;
  typedef logic [mftd_pkg::CFG_W-1:0]   cfg_word_t;

  // --------------------------------------------------------------------------
  // Tap predictor and store of expected counts
  // --------------------------------------------------------------------------
  class tap_scoreboard;
    bit             slot_down [SLOTS];
    stamp_t         press_at  [SLOTS];
    stamp_t         release_at[SLOTS];
    mftd_pkg::cfg_t regs;
    tap_t           expected_taps[$];
    int unsigned    errors;

    function new();
      for (int i = 0; i < SLOTS; i++) begin
        slot_down[i]  = 1'b0;
        press_at[i]   = '0;
        release_at[i] = '0;
      end
      regs.settle_ms     = mftd_pkg::SETTLE_RST;
      regs.recent_ms     = mftd_pkg::RECENT_RST;
      regs.long_press_ms = mftd_pkg::LONG_PRESS_RST;
      errors             = 0;
    endfunction

    function void set_reg(mftd_pkg::cfg_reg_e idx, cfg_word_t v);
      case (idx)
        mftd_pkg::REG_SETTLE:     regs.settle_ms     = v;
        mftd_pkg::REG_RECENT:     regs.recent_ms     = v;
        mftd_pkg::REG_LONG_PRESS: regs.long_press_ms = v;
        default: ;
      endcase
    endfunction

    // Update slot edges, then count recent short holds once all are up and one has settled
    function void note_sample(mask_t mask, stamp_t now);
      bit          any_down;
      bit          settled;
      int unsigned fingers;
      stamp_t      age;
      stamp_t      hold;
      any_down = 1'b0;
      settled  = 1'b0;
      fingers  = 0;
      for (int i = 0; i < SLOTS; i++) begin
        if (!slot_down[i] && mask[i]) begin
          slot_down[i] = 1'b1;
          press_at[i]  = now;
        end else if (slot_down[i] && !mask[i]) begin
          slot_down[i]  = 1'b0;
          release_at[i] = now;
        end
        if (mask[i]) any_down = 1'b1;
      end
      if (!any_down) begin
        for (int i = 0; i < SLOTS; i++) begin
          age = now - release_at[i];
          if (age >= stamp_t'(regs.settle_ms)) settled = 1'b1;
        end
        if (settled) begin
          for (int i = 0; i < SLOTS; i++) begin
            age  = now - release_at[i];
            hold = release_at[i] - press_at[i];
            if (age <= stamp_t'(regs.recent_ms) && hold <= stamp_t'(regs.long_press_ms))
              fingers++;
          end
        end
      end
      expected_taps.push_back(tap_t'(fingers));
    endfunction

    function void check_result(tap_t got);
      tap_t want;
      if (expected_taps.size() == 0) begin
        $error("unexpected result: tap_fingers actual %0d, nothing outstanding", got);
        errors++;
        return;
      end
      want = expected_taps.pop_front();
      if (got !== want) begin
        $error("tap_fingers mismatch: expected %0d, actual %0d", want, got);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return expected_taps.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset, channels and the block
  // --------------------------------------------------------------------------
  logic clk;
  logic rst;

  mftd_in_if  sample_if();
  mftd_out_if result_if();
  mftd_cfg_if cfg_if();

  multi_finger_tap_detector_top #(
    .MAX_SLOTS (SLOTS)
  ) u_top (
    .clk    (clk),
    .rst    (rst),
    .sample (sample_if),
    .result (result_if),
    .cfg    (cfg_if)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  tap_scoreboard sb = new();
  int unsigned   samples_sent = 0;
  int unsigned   idle_cycles  = 0;
  bit            hold_off_req = 1'b0;
  bit            send_calm    = 1'b0;
  stamp_t        t_ms         = '0;

  // Gap length: mostly short, a few long; none in a calm stretch
  function automatic int unsigned pick_gap(bit calm);
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(20, 60);
  endfunction

  // --------------------------------------------------------------------------
  // Monitor: note accepted samples, check accepted results, watchdog
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (sample_if.valid === 1'b1 && sample_if.ready === 1'b1)
      sb.note_sample(sample_if.pressed_mask, sample_if.now_ms);
    if (result_if.valid === 1'b1 && result_if.ready === 1'b1)
      sb.check_result(result_if.tap_fingers);
    if ((sample_if.valid === 1'b1 && sample_if.ready === 1'b1) ||
        (result_if.valid === 1'b1 && result_if.ready === 1'b1) ||
        (cfg_if.valid === 1'b1 && cfg_if.ready === 1'b1))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Result receiver with random back-pressure and the long hold-off
  // --------------------------------------------------------------------------
  initial begin : receiver
    int unsigned stall_left;
    bit          calm;
    stall_left = 0;
    calm       = 1'b0;
    result_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if ($urandom_range(0, 149) == 0) calm = !calm;
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        stall_left   = LONG_HOLD;
      end
      if (stall_left > 0) begin
        result_if.ready <= 1'b0;
        stall_left--;
      end else begin
        result_if.ready <= 1'b1;
        stall_left = pick_gap(calm);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sender tasks
  // --------------------------------------------------------------------------
  task automatic send_sample(mask_t m, stamp_t now);
    int unsigned gap;
    sample_if.valid        <= 1'b1;
    sample_if.pressed_mask <= m;
    sample_if.now_ms       <= now;
    do @(posedge clk); while (sample_if.ready !== 1'b1);
    samples_sent++;
    if ($urandom_range(0, 119) == 0) send_calm = !send_calm;
    gap = pick_gap(send_calm);
    if (gap != 0) begin
      sample_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Advance the running clock and send one item
  task automatic step_sample(mask_t m, int unsigned dt);
    t_ms = t_ms + stamp_t'(dt);
    send_sample(m, t_ms);
  endtask

  // Stop offering and wait for every outstanding count, then a quiet spell
  task automatic drain_results();
    sample_if.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(mftd_pkg::cfg_reg_e idx, cfg_word_t v);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= v;
    do @(posedge clk); while (cfg_if.ready !== 1'b1);
    sb.set_reg(idx, v);
  endtask

  // Only called with the block idle
  task automatic apply_setting(cfg_word_t settle, cfg_word_t recent, cfg_word_t long_press);
    write_reg(mftd_pkg::REG_SETTLE, settle);
    write_reg(mftd_pkg::REG_RECENT, recent);
    write_reg(mftd_pkg::REG_LONG_PRESS, long_press);
    cfg_if.valid <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Stimulus shapes
  // --------------------------------------------------------------------------
  // Well-formed tap: staggered press, hold, staggered release, idle ticks
  task automatic run_gesture();
    mask_t       fingers;
    mask_t       cur;
    int unsigned hold_target;
    int unsigned holds;
    int unsigned span;
    int unsigned idles;
    fingers = mask_t'($urandom_range(1, 31));
    cur     = '0;
    if ($urandom_range(0, 15) == 0)
      t_ms = 32'hFFFF_FFFF - stamp_t'($urandom_range(0, 3000));
    while (cur != fingers) begin
      cur = cur | (fingers & mask_t'($urandom));
      step_sample(cur, $urandom_range(0, 15));
    end
    hold_target = $urandom_range(0, sb.regs.long_press_ms + sb.regs.long_press_ms / 4 + 4);
    holds       = $urandom_range(0, 3);
    for (int i = 0; i < holds; i++)
      step_sample(cur, hold_target / (holds + 1));
    t_ms = t_ms + stamp_t'(hold_target / (holds + 1));
    while (cur != '0) begin
      cur = cur & mask_t'($urandom);
      step_sample(cur, $urandom_range(0, 15));
    end
    span  = 32'((sb.regs.settle_ms > sb.regs.recent_ms) ? sb.regs.settle_ms
                                                         : sb.regs.recent_ms);
    idles = $urandom_range(2, 6);
    for (int i = 0; i < idles; i++)
      step_sample('0, $urandom_range(0, span / 2 + 8));
  endtask

  // Broken sequence: arbitrary mask changes at short intervals
  task automatic run_broken();
    int unsigned n;
    n = $urandom_range(2, 6);
    for (int i = 0; i < n; i++)
      step_sample(mask_t'($urandom), $urandom_range(0, 40));
  endtask

  // Noise: random mask with a jump in time, sometimes anywhere
  task automatic run_noise();
    if ($urandom_range(0, 1) == 0) t_ms = stamp_t'($urandom);
    else                           t_ms = t_ms + stamp_t'($urandom_range(0, 1000));
    send_sample(mask_t'($urandom), t_ms);
  endtask

  task automatic run_random(int unsigned count);
    int unsigned end_at;
    int unsigned pick;
    end_at = samples_sent + count;
    while (samples_sent < end_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 75)      run_gesture();
      else if (pick < 90) run_broken();
      else                run_noise();
    end
  endtask

  // Opening: untouched slots, full hand, a long hold, the wrap, extremes
  task automatic run_directed();
    send_sample(5'h00, 32'h0000_0000);   // nothing released long enough yet
    send_sample(5'h00, 32'h0000_003C);   // untouched slots count as taps
    send_sample(5'h1F, 32'h0000_0064);   // all five down
    send_sample(5'h1F, 32'h0000_0096);
    send_sample(5'h00, 32'h0000_00B4);   // all five up
    send_sample(5'h00, 32'h0000_00C8);   // not settled yet
    send_sample(5'h00, 32'h0000_00F0);   // five-finger tap
    send_sample(5'h00, 32'h0000_00F8);   // reported again
    send_sample(5'h00, 32'h0000_0200);   // aged out of the window
    send_sample(5'h01, 32'h0000_0300);
    send_sample(5'h00, 32'h0000_0600);   // hold too long
    send_sample(5'h00, 32'h0000_0640);
    send_sample(5'h15, 32'hFFFF_FFF0);   // press just before the wrap
    send_sample(5'h0A, 32'hFFFF_FFFF);
    send_sample(5'h00, 32'h0000_0010);   // release across the wrap
    send_sample(5'h00, 32'h0000_0050);
    send_sample(5'h10, 32'h8000_0000);
    send_sample(5'h00, 32'h8000_0001);
    send_sample(5'h00, 32'h8000_0040);
    send_sample(5'h1F, 32'hFFFF_FFFF);
    send_sample(5'h00, 32'hFFFF_FFFF);   // zero hold, zero age
    t_ms = 32'h0000_1000;
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    rst                    <= 1'b1;
    sample_if.valid        <= 1'b0;
    sample_if.pressed_mask <= '0;
    sample_if.now_ms       <= '0;
    cfg_if.valid           <= 1'b0;
    cfg_if.index           <= mftd_pkg::REG_SETTLE;
    cfg_if.data            <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset settings
    run_directed();
    run_random(PHASE_ITEMS);
    drain_results();

    apply_setting(16'd0, 16'd0, 16'd0);
    run_random(PHASE_ITEMS);
    drain_results();

    apply_setting(16'hFFFF, 16'hFFFF, 16'hFFFF);
    run_random(PHASE_ITEMS);
    drain_results();

    // Small random setting, with the long output hold-off mid-phase
    apply_setting(cfg_word_t'($urandom_range(0, 300)), cfg_word_t'($urandom_range(0, 300)),
                  cfg_word_t'($urandom_range(0, 300)));
    run_random(50);
    hold_off_req = 1'b1;
    run_random(PHASE_ITEMS - 50);
    drain_results();

    apply_setting(16'd0, 16'hFFFF, 16'hFFFF);
    run_random(PHASE_ITEMS);
    drain_results();

    apply_setting(16'hFFFF, 16'd0, 16'd0);
    run_random(PHASE_ITEMS);
    drain_results();

    // Back to the reset values, with a full sender pause mid-phase
    apply_setting(mftd_pkg::SETTLE_RST, mftd_pkg::RECENT_RST, mftd_pkg::LONG_PRESS_RST);
    run_random(60);
    drain_results();
    run_random(PHASE_ITEMS - 60);
    drain_results();

    apply_setting(cfg_word_t'($urandom), cfg_word_t'($urandom), cfg_word_t'($urandom));
    run_random(PHASE_ITEMS);
    drain_results();

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== multi_finger_tap_detector_top.f =====
rtl/mftd_pkg.sv
rtl/mftd_if.sv
rtl/mftd_cfg_regs.sv
rtl/mftd_slot_lane.sv
rtl/multi_finger_tap_detector_top.sv
tb/sv/multi_finger_tap_detector_top_tb.sv
